/* rtl/core/gvc_pkg.sv */
// shared types and constants for the grid vote consensus block
`default_nettype none

package gvc_pkg;

    localparam int VOTE_W = 2;
    localparam int DIST_W = 16;
    localparam int CNT_W  = 7;
    localparam int SUM_W  = 22;

    localparam logic [VOTE_W-1:0] VOTE_NEG = 2'd0;
    localparam logic [VOTE_W-1:0] VOTE_POS = 2'd1;

    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;
    localparam logic signed [SUM_W:0] SUM_MAX = 23'sd2097151;
    localparam logic signed [SUM_W:0] SUM_MIN = -23'sd2097152;

    localparam logic [DIST_W-1:0] MEAN_POS_LIM = 16'h7FFF;
    localparam logic [DIST_W-1:0] MEAN_NEG_LIM = 16'h8000;

    // one quotient bit per step over the sum magnitude
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic acc_en;    // accumulate the accepted cell
        logic load;      // pick winner, load divider, clear sums
        logic div_step;  // one divider iteration
        logic out_load;  // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic last_step; // divider is on its final iteration
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/core/gvc_datapath.sv */
// accumulators, winner select, serial divider and output register
`default_nettype none

module gvc_datapath
    import gvc_pkg::*;
#(
    parameter int MAX_CELLS = 64
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  wire  [VOTE_W-1:0]       i_vote,
    input  wire  signed [DIST_W-1:0] i_distance,
    output logic                    o_label,
    output logic signed [DIST_W-1:0] o_mean_distance,
    output logic                    o_no_votes
);

    localparam int LIM_W = $clog2(MAX_CELLS + 1);
    localparam int TOT_W = (LIM_W > CNT_W + 1) ? LIM_W : CNT_W + 1;
    localparam logic [TOT_W-1:0] TOT_LIM = TOT_W'(MAX_CELLS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic [CNT_W-1:0]        r_pos_cnt, r_neg_cnt;
    logic signed [SUM_W-1:0] r_pos_sum, r_neg_sum;

    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic              r_label;
    logic              r_none;

    logic                    r_out_label;
    logic [DIST_W-1:0]       r_out_mean;
    logic                    r_out_none;

    logic [TOT_W-1:0]        tot;
    logic                    room;
    logic signed [SUM_W:0]   add_base, add_res, add_sat;
    logic signed [SUM_W:0]   neg_ext, neg_abs, pos_ext;
    logic                    n_label, n_none;
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]        sel_mag;
    logic [CNT_W:0]          rem_sh, rem_sub;
    logic                    rem_ge;
    logic [DIST_W-1:0]       n_mean;

    // saturating accumulate of the cell distance into the voted side
    always_comb begin
        tot      = TOT_W'(r_pos_cnt) + TOT_W'(r_neg_cnt);
        room     = tot < TOT_LIM;
        add_base = (i_vote == VOTE_POS) ? (SUM_W+1)'(r_pos_sum) : (SUM_W+1)'(r_neg_sum);
        add_res  = add_base + (SUM_W+1)'(i_distance);
        if (add_res > SUM_MAX) begin
            add_sat = SUM_MAX;
        end else if (add_res < SUM_MIN) begin
            add_sat = SUM_MIN;
        end else begin
            add_sat = add_res;
        end
    end

    // winner decision from the finished accumulators
    always_comb begin
        pos_ext = (SUM_W+1)'(r_pos_sum);
        neg_ext = (SUM_W+1)'(r_neg_sum);
        neg_abs = r_neg_sum[SUM_W-1] ? -neg_ext : neg_ext;
        n_none  = (r_pos_cnt == '0) && (r_neg_cnt == '0);
        priority if (n_none) begin
            n_label = 1'b0;
        end else if (r_pos_cnt > r_neg_cnt) begin
            n_label = 1'b1;
        end else if (r_pos_cnt < r_neg_cnt) begin
            n_label = 1'b0;
        end else begin
            n_label = pos_ext > neg_abs;
        end
        sel_sum = n_label ? r_pos_sum : r_neg_sum;
        sel_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
    end

    // restoring divide, one quotient bit per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        rem_ge  = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    // sign and saturate the quotient into the 16-bit mean
    always_comb begin
        if (r_none) begin
            n_mean = '0;
        end else if (r_neg) begin
            n_mean = (r_quo > SUM_W'(MEAN_NEG_LIM)) ? MEAN_NEG_LIM
                                                     : DIST_W'(~r_quo[DIST_W-1:0] + 1'b1);
        end else begin
            n_mean = (r_quo > SUM_W'(MEAN_POS_LIM)) ? MEAN_POS_LIM : r_quo[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_cnt <= '0;
            r_neg_cnt <= '0;
            r_pos_sum <= '0;
            r_neg_sum <= '0;
            r_step    <= '0;
        end else if (i_cmd.load) begin
            r_pos_cnt <= '0;
            r_neg_cnt <= '0;
            r_pos_sum <= '0;
            r_neg_sum <= '0;
            r_step    <= '0;
        end else begin
            if (i_cmd.acc_en && room) begin
                if (i_vote == VOTE_POS) begin
                    if (r_pos_cnt != COUNT_MAX) begin
                        r_pos_cnt <= r_pos_cnt + 1'b1;
                    end
                    r_pos_sum <= add_sat[SUM_W-1:0];
                end else if (i_vote == VOTE_NEG) begin
                    if (r_neg_cnt != COUNT_MAX) begin
                        r_neg_cnt <= r_neg_cnt + 1'b1;
                    end
                    r_neg_sum <= add_sat[SUM_W-1:0];
                end
            end
            if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= sel_mag;
            r_rem   <= '0;
            r_div   <= n_label ? r_pos_cnt : r_neg_cnt;
            r_neg   <= sel_sum[SUM_W-1];
            r_label <= n_label;
            r_none  <= n_none;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_label <= r_label;
            r_out_mean  <= n_mean;
            r_out_none  <= r_none;
        end
    end

    assign o_sts.last_step = (r_step == STEP_LAST);
    assign o_label         = r_out_label;
    assign o_mean_distance = r_out_mean;
    assign o_no_votes      = r_out_none;

endmodule

`default_nettype wire

/* rtl/core/gvc_ctrl.sv */
// sequencer for accumulate, load, divide and emit
`default_nettype none

module gvc_ctrl
    import gvc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    input  wire      i_in_last,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_sts  i_sts
);

    typedef enum logic [1:0] {
        S_ACC,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;
    logic   in_take;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_take  = i_in_valid && (r_state == S_ACC);

    always_comb begin
        o_cmd.acc_en   = in_take;
        o_cmd.load     = (r_state == S_LOAD);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_EMIT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_ACC: begin
                    if (in_take && i_in_last) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.last_step) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_out_valid;

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> !o_in_ready)
        else $error("input still taken after the closing cell");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote an untaken item");

    a_load_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DIV))
        else $error("divider not started after load");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && i_sts.last_step) |=> (r_state == S_EMIT))
        else $error("divider end not followed by emit");

endmodule

`default_nettype wire

/* rtl/core/grid_vote_consensus_top.sv */
// one input item per cycle while a sample accumulates; after the closing cell the
// input stalls for load, 22 divider iterations and emit, so the result item is
// loaded into the output register as emit ends, which raises valid and resumes input
// (emit waits only while the previous result item is still untaken)
// the serial divider holds input off, so cells of the next sample wait for the result
// synchronous active-low reset clears counts, sums, sequencer and output valid
`default_nettype none

module grid_vote_consensus_top
    import gvc_pkg::*;
#(
    parameter int MAX_CELLS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,  // vote[1:0], distance[17:2], zero pad
    input  wire         i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // label[0], mean_distance[16:1], zero pad
    output logic        o_m_axis_tuser   // no_votes[0]
);

    t_dp_cmd                 cmd;
    t_dp_sts                 sts;
    logic                    label;
    logic signed [DIST_W-1:0] mean_distance;
    logic                    no_votes;

    gvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_last   (i_s_axis_tlast),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    gvc_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_vote          (i_s_axis_tdata[VOTE_W-1:0]),
        .i_distance      (i_s_axis_tdata[VOTE_W+DIST_W-1:VOTE_W]),
        .o_label         (label),
        .o_mean_distance (mean_distance),
        .o_no_votes      (no_votes)
    );

    assign o_m_axis_tdata = {7'd0, mean_distance, label};
    assign o_m_axis_tuser = no_votes;

endmodule

`default_nettype wire

/* test/tb.sv */
// self-checking bench for grid_vote_consensus_top: directed and random samples checked against a vote tally
`timescale 1ns / 100ps

module tb
    import gvc_pkg::*;
();

    localparam int CELL_LIMIT = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 258;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [VOTE_W-1:0] VOTE_ABSTAIN = 2'd2;
    localparam logic [VOTE_W-1:0] VOTE_SPARE   = 2'd3;

    localparam logic signed [DIST_W-1:0] DIST_TOP    = 16'sh7FFF;
    localparam logic signed [DIST_W-1:0] DIST_BOTTOM = 16'sh8000;

    typedef struct {
        logic [VOTE_W-1:0]        vote;
        logic signed [DIST_W-1:0] distance;
        logic                     last;
    } t_cell;

    typedef struct {
        logic                     label;
        logic signed [DIST_W-1:0] mean;
        logic                     none;
    } t_verdict;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    t_cell    pending_cells[$];
    t_verdict verdict_q[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_len = 0;
    int hold_left = 0;
    bit hold_taken = 1'b0;
    int errors = 0;
    int cycle_cnt = 0;

    // tally state of the sample in progress
    logic [CNT_W-1:0]        pos_cnt = '0;
    logic [CNT_W-1:0]        neg_cnt = '0;
    logic signed [SUM_W-1:0] pos_sum = '0;
    logic signed [SUM_W-1:0] neg_sum = '0;

    grid_vote_consensus_top #(
        .MAX_CELLS(CELL_LIMIT)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] acc,
                                                       logic signed [DIST_W-1:0] d);
        logic signed [SUM_W:0] t;
        t = acc + d;
        if (t > SUM_MAX) t = SUM_MAX;
        if (t < SUM_MIN) t = SUM_MIN;
        return t[SUM_W-1:0];
    endfunction

    function automatic logic signed [DIST_W-1:0] side_mean(logic signed [SUM_W-1:0] s,
                                                          logic [CNT_W-1:0] n);
        int q;
        if (n == 0) return '0;
        q = int'(s) / int'(n);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[DIST_W-1:0];
    endfunction

    // fold one accepted cell into the tally; returns 1 when the sample closes
    function automatic bit tally_cell(t_cell c, output t_verdict v);
        bit room;
        int mag;
        room = (int'(pos_cnt) + int'(neg_cnt)) < CELL_LIMIT;
        if (room && c.vote == VOTE_NEG) begin
            if (neg_cnt < COUNT_MAX) neg_cnt = neg_cnt + 1'b1;
            neg_sum = sat_add(neg_sum, c.distance);
        end else if (room && c.vote == VOTE_POS) begin
            if (pos_cnt < COUNT_MAX) pos_cnt = pos_cnt + 1'b1;
            pos_sum = sat_add(pos_sum, c.distance);
        end
        v.label = 1'b0;
        v.mean = '0;
        v.none = 1'b0;
        if (!c.last) return 1'b0;
        if (pos_cnt == 0 && neg_cnt == 0) begin
            v.none = 1'b1;
        end else begin
            if (pos_cnt > neg_cnt) begin
                v.label = 1'b1;
            end else if (pos_cnt < neg_cnt) begin
                v.label = 1'b0;
            end else begin
                mag = (neg_sum < 0) ? -int'(neg_sum) : int'(neg_sum);
                v.label = int'(pos_sum) > mag;
            end
            v.mean = v.label ? side_mean(pos_sum, pos_cnt) : side_mean(neg_sum, neg_cnt);
        end
        pos_cnt = '0;
        neg_cnt = '0;
        pos_sum = '0;
        neg_sum = '0;
        return 1'b1;
    endfunction

    // sender
    always @(posedge clk) begin
        t_cell c;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_cells.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                c = pending_cells.pop_front();
                s_tdata  <= {6'b0, c.distance, c.vote};
                s_tlast  <= c.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off when requested
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_len != 0 && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= hold_len;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= rx_stall_pct;
        end
    end

    // monitor: check results first, then fold in the accepted cell
    always @(posedge clk) begin
        t_cell    c;
        t_verdict v;
        t_verdict w;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t unexpected result: label %0b mean %0d no_votes %0b",
                             $time, m_tdata[0], $signed(m_tdata[16:1]), m_tuser);
                    errors++;
                end else begin
                    w = verdict_q.pop_front();
                    if (m_tdata[0] !== w.label) begin
                        $display("%0t label: expected %0b actual %0b",
                                 $time, w.label, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[16:1] !== w.mean) begin
                        $display("%0t mean_distance: expected %0d actual %0d",
                                 $time, w.mean, $signed(m_tdata[16:1]));
                        errors++;
                    end
                    if (m_tuser !== w.none) begin
                        $display("%0t no_votes: expected %0b actual %0b",
                                 $time, w.none, m_tuser);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                c.vote = s_tdata[1:0];
                c.distance = s_tdata[17:2];
                c.last = s_tlast;
                if (tally_cell(c, v)) verdict_q = {verdict_q, v};
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_cell(logic [VOTE_W-1:0] vote, logic signed [DIST_W-1:0] distance,
                             logic last);
        t_cell c;
        c.vote = vote;
        c.distance = distance;
        c.last = last;
        pending_cells = {pending_cells, c};
    endtask

    function automatic logic signed [DIST_W-1:0] rand_dist();
        logic [31:0] r;
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: return DIST_TOP;
                1: return DIST_BOTTOM;
                2: return '0;
                default: return -16'sd1;
            endcase
        end
        r = $urandom();
        return r[DIST_W-1:0];
    endfunction

    function automatic logic [VOTE_W-1:0] rand_vote();
        int r;
        r = $urandom_range(99);
        if (r < 42) return VOTE_POS;
        if (r < 84) return VOTE_NEG;
        if (r < 96) return VOTE_ABSTAIN;
        return VOTE_SPARE;
    endfunction

    // mostly short samples, some near the cell limit and a few past it
    task automatic queue_random_samples(int target);
        int added;
        int n;
        int r;
        added = 0;
        while (added < target) begin
            r = $urandom_range(99);
            if (r < 88) n = $urandom_range(12, 1);
            else if (r < 96) n = $urandom_range(64, 20);
            else n = $urandom_range(90, 65);
            for (int k = 0; k < n; k++)
                push_cell(rand_vote(), rand_dist(), k == n - 1);
            added += n;
        end
    endtask

    task automatic queue_directed();
        // empty samples: abstain only, spare vote code only
        push_cell(VOTE_ABSTAIN, DIST_TOP, 1'b1);
        push_cell(VOTE_SPARE, DIST_BOTTOM, 1'b1);
        // positive majority at the top distance
        push_cell(VOTE_POS, DIST_TOP, 1'b0);
        push_cell(VOTE_POS, DIST_TOP, 1'b0);
        push_cell(VOTE_NEG, DIST_BOTTOM, 1'b1);
        // negative majority at the bottom distance
        push_cell(VOTE_NEG, DIST_BOTTOM, 1'b0);
        push_cell(VOTE_NEG, DIST_BOTTOM, 1'b1);
        // tie won by the positive sum
        push_cell(VOTE_POS, 16'sd300, 1'b0);
        push_cell(VOTE_NEG, -16'sd200, 1'b1);
        // tie with equal magnitudes goes negative
        push_cell(VOTE_POS, 16'sd200, 1'b0);
        push_cell(VOTE_NEG, -16'sd200, 1'b1);
        // tie where the negative side has a positive sum
        push_cell(VOTE_POS, 16'sd5, 1'b0);
        push_cell(VOTE_NEG, 16'sd100, 1'b1);
        // negative mean truncated toward zero
        push_cell(VOTE_NEG, -16'sd7, 1'b0);
        push_cell(VOTE_NEG, -16'sd9, 1'b0);
        push_cell(VOTE_NEG, 16'sd0, 1'b1);
        // ignored votes carry extreme distances
        push_cell(VOTE_POS, 16'sd10, 1'b0);
        push_cell(VOTE_ABSTAIN, DIST_BOTTOM, 1'b0);
        push_cell(VOTE_SPARE, DIST_TOP, 1'b1);
    endtask

    task automatic wait_drained();
        while (pending_cells.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no idling, one long receiver hold-off while cells keep coming
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        queue_directed();
        hold_len = LONG_HOLD;
        queue_random_samples(RANDOM_PER_PHASE);
        wait_drained();

        tx_idle_pct = 78;
        rx_stall_pct = 0;
        queue_random_samples(RANDOM_PER_PHASE);
        wait_drained();

        tx_idle_pct = 0;
        rx_stall_pct = 78;
        queue_random_samples(RANDOM_PER_PHASE);
        wait_drained();

        tx_idle_pct = 15;
        rx_stall_pct = 15;
        queue_random_samples(RANDOM_PER_PHASE);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
